FILE: rtl/core/fsf_pkg.sv
package fsf_pkg;

	localparam int MAX_TAPS       = 256;
	localparam int COEF_FRAC_BITS = 15;
	localparam int SAMPLE_W       = 16;
	localparam int IDX_W          = $clog2(MAX_TAPS);
	localparam int ACC_W          = 2 * SAMPLE_W + IDX_W;
	localparam int TAP_CNT_W      = 9;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(256);

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

	// Request codes carried in req_type.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	// Register word index, taken from paddr[2].
	localparam logic REG_TAP_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} hist_t;

	typedef struct packed {
		hist_t                      hist;
		logic signed [SAMPLE_W-1:0] coef;
	} cell_data_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctrl_t;

	typedef struct packed {
		logic clear;
		logic tap_en;
	} mac_ctrl_t;

endpackage

FILE: rtl/core/fsf_if.sv
interface fsf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic signed [fsf_pkg::SAMPLE_W-1:0]  left_sample;
	logic signed [fsf_pkg::SAMPLE_W-1:0]  right_sample;
	logic        [7:0]                    coef_index;
	logic signed [fsf_pkg::SAMPLE_W-1:0]  coef_value;

	modport source (
		output valid, req_type, left_sample, right_sample, coef_index, coef_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, left_sample, right_sample, coef_index, coef_value,
		output ready
	);
endinterface

interface fsf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fsf_pkg::SAMPLE_W-1:0]  left_out;
	logic signed [fsf_pkg::SAMPLE_W-1:0]  right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

FILE: rtl/core/fsf_cell.sv
module fsf_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fsf_pkg::cell_ctrl_t               ctrl,
	input  fsf_pkg::hist_t                    shift_in,
	input  fsf_pkg::cell_data_t               rot_in,
	input  logic                              coef_we,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0] coef_wdata,
	output fsf_pkg::cell_data_t               data
);
	import fsf_pkg::*;

	hist_t                      hist_q;
	logic signed [SAMPLE_W-1:0] coef_q;

	// Delay line entry: a new sample pushes the line one place back, a
	// rotation step moves it one place forward toward the MAC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctrl.shift) begin
			hist_q <= shift_in;
		end else if (ctrl.rotate) begin
			hist_q <= rot_in.hist;
		end
	end

	// The coefficient rotates along with its sample so the pairs stay aligned.
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_q <= coef_wdata;
		end else if (ctrl.rotate) begin
			coef_q <= rot_in.coef;
		end
	end

	assign data.hist = hist_q;
	assign data.coef = coef_q;

endmodule

FILE: rtl/core/fsf_mac.sv
module fsf_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fsf_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0] coef,
	output logic signed [fsf_pkg::SAMPLE_W-1:0] result
);
	import fsf_pkg::*;

	logic signed [2*SAMPLE_W-1:0] prod_s1;
	logic                         en_s1;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      biased;
	logic signed [ACC_W-1:0]      quot;

	always_ff @(posedge clk) begin
		prod_s1 <= (2*SAMPLE_W)'(sample) * (2*SAMPLE_W)'(coef);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			en_s1 <= ctrl.tap_en;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (en_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	// Shift with truncation toward zero: negative sums get a bias of one
	// less than the divisor before the arithmetic shift.
	always_comb begin
		biased = acc_q;
		if (acc_q < 0) begin
			biased = acc_q + ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
		end
		quot = biased >>> COEF_FRAC_BITS;
		if (quot > ACC_W'(SAT_MAX)) begin
			result = SAT_MAX;
		end else if (quot < ACC_W'(SAT_MIN)) begin
			result = SAT_MIN;
		end else begin
			result = quot[SAMPLE_W-1:0];
		end
	end

endmodule

FILE: rtl/core/stereo_fir_saturating_filter.sv
// Stereo direct-form FIR low-pass filter with one shared coefficient table.
// The input channel carries words of two kinds. A sample word (req_type 0)
// pushes its left and right samples into the two delay lines and produces
// one output word with both filtered channels, each the tap sum truncated
// toward zero from Q15 and saturated to 16 bits. A coefficient word
// (req_type 1) loads one tap and produces nothing.
// The tap_count register (APB, byte address 0) sets the taps in use.
// Load every tap in use before the first sample word.
// For a sample word, the delay line and the coefficients sit in a row of
// cells that rotates once all the way around, feeding one multiply-accumulate
// unit per channel at the head cell; then the flush state drains the product
// register and the finish state loads the output.
// The next word is accepted once the result is in the output register, which
// lets a finished result wait while the next word is taken in.
// If the receiver stalls, a finished second result waits in its last step
// until the output register is free, and no further word is accepted.
// Reset clears both delay lines to zero and sets tap_count to 256; the
// coefficient table holds no defined value until written.
module stereo_fir_saturating_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	fsf_in_if.sink                                sample_in,
	fsf_out_if.source                             result_out,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fsf_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [fsf_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [fsf_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);
	import fsf_pkg::*;

	state_t                     state_q;
	state_t                     state_d;
	logic [IDX_W-1:0]           cnt_q;
	logic [IDX_W-1:0]           cnt_d;
	logic [TAP_CNT_W-1:0]       tap_count_q;

	logic                       in_accept;
	logic                       sample_accept;
	logic                       coef_accept;
	logic                       out_load;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_out_q;
	logic signed [SAMPLE_W-1:0] right_out_q;
	logic signed [SAMPLE_W-1:0] left_res;
	logic signed [SAMPLE_W-1:0] right_res;

	cell_ctrl_t                 cell_ctrl;
	mac_ctrl_t                  mac_ctrl;
	cell_data_t                 tap_data [MAX_TAPS];
	logic [MAX_TAPS-1:0]        coef_we;
	hist_t                      new_hist;

	// Configuration port. The word index is paddr[2]; only word 0 exists.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT) begin
			tap_count_q <= pwdata[TAP_CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TAP_COUNT) begin
			prdata = APB_DATA_W'(tap_count_q);
		end
	end

	// Input handshake.
	assign sample_in.ready = (state_q == ST_IDLE);
	assign in_accept       = sample_in.valid && sample_in.ready;
	assign sample_accept   = in_accept && sample_in.req_type == REQ_SAMPLE;
	assign coef_accept     = in_accept && sample_in.req_type == REQ_COEF;

	assign new_hist.left  = sample_in.left_sample;
	assign new_hist.right = sample_in.right_sample;

	// Sequencer: one full rotation of the cell row, then drain and output.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (sample_accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == IDX_W'(MAX_TAPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_FLUSH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FLUSH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || result_out.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign cell_ctrl.shift  = sample_accept;
	assign cell_ctrl.rotate = (state_q == ST_RUN);

	// A tap beyond the count in use is skipped; a count above the depth
	// simply enables every tap.
	assign mac_ctrl.clear  = sample_accept;
	assign mac_ctrl.tap_en = (state_q == ST_RUN) && (32'(cnt_q) < 32'(tap_count_q));

	// Row of cells. Cell k holds tap k at rest; during the rotation the head
	// cell presents tap cnt to the MAC units, and after a full turn the row
	// is back in place.
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cells
		hist_t shift_src;

		if (k == 0) begin : g_head
			assign shift_src = new_hist;
		end else begin : g_body
			assign shift_src = tap_data[k-1].hist;
		end

		assign coef_we[k] = coef_accept && (32'(sample_in.coef_index) == k);

		fsf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.shift_in   (shift_src),
			.rot_in     (tap_data[(k + 1) % MAX_TAPS]),
			.coef_we    (coef_we[k]),
			.coef_wdata (sample_in.coef_value),
			.data       (tap_data[k])
		);
	end

	fsf_mac u_mac_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (tap_data[0].hist.left),
		.coef   (tap_data[0].coef),
		.result (left_res)
	);

	fsf_mac u_mac_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (tap_data[0].hist.right),
		.coef   (tap_data[0].coef),
		.result (right_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out_q  <= left_res;
			right_out_q <= right_res;
		end
	end

	assign result_out.valid     = out_valid_q;
	assign result_out.left_out  = left_out_q;
	assign result_out.right_out = right_out_q;

	// A sample word starts a rotation from the first tap.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		sample_accept |=> (state_q == ST_RUN && cnt_q == '0))
		else $error("rotation did not start after a sample word");

	// The rotation lasts exactly one full turn of the row.
	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == IDX_W'(MAX_TAPS - 1)) |=> state_q == ST_FLUSH)
		else $error("rotation did not end after a full turn");

	// No word is taken in while a sample is being filtered.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_accept)
		else $error("word accepted while busy");

	// A finished result lands in the output register.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not presented after load");

	// Nothing overwrites a result that is still waiting.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready) |-> !out_load)
		else $error("waiting result overwritten");

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the stereo FIR filter.
//
// A queue of pending input words is filled by the stimulus process. A clocked
// driver sends those words in bursts with random gaps. A clocked monitor takes
// the output words while the receiver stalls on its own pattern. Every word
// accepted by the filter also runs through a local predictor. The predictor
// keeps its own delay lines, coefficient table and tap count. Each sample word
// adds one expected output pair, and the monitor checks the pairs in order.
module testbench;
	import fsf_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int LIMIT_CYCLES    = 3000000;
	// This margin covers any word still in flight when the output goes quiet.
	localparam int SETTLE_CYCLES   = MAX_TAPS + 8;
	localparam int RANDOM_PHASES   = 10;
	localparam int WORDS_PER_PHASE = 17;

	// The tap count register is word 0, which is selected by paddr[2].
	localparam logic [APB_ADDR_W-1:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};

	typedef struct {
		logic                       req_type;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [7:0]                 tap;
		logic signed [SAMPLE_W-1:0] coef;
	} word_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} out_pair_t;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_HOLDOFF} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	fsf_in_if  sample_if ();
	fsf_out_if result_if ();

	stereo_fir_saturating_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_if),
		.result_out (result_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Predictor state. This mirrors the filter as seen from its ports.
	logic signed [SAMPLE_W-1:0] left_line   [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] right_line  [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] coef_shadow [MAX_TAPS];
	logic [TAP_CNT_W-1:0]       tap_setting;

	// Stimulus bookkeeping. The filter must never read a table entry that has
	// not been written, so the generator tracks which entries it has loaded.
	bit coef_loaded [MAX_TAPS];
	int coef_span;

	word_t     pending_words[$];
	out_pair_t filtered_pairs_due[$];
	int        error_count;

	word_t    on_bus;
	int       burst_left;
	int       gap_left;
	rx_mode_t rx_mode;
	int       rx_mode_left;
	int       stall_left;

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] saturate(input longint q);
		if (q > SAT_MAX)
			return SAT_MAX;
		if (q < SAT_MIN)
			return SAT_MIN;
		return q[SAMPLE_W-1:0];
	endfunction

	// Apply one accepted word to the predictor. A coefficient word only updates
	// the table. A sample word shifts the entire delay line, whatever the tap
	// count, and then forms both dot products over the taps in use.
	task automatic filter_word(input word_t w);
		longint    acc_l;
		longint    acc_r;
		int        taps;
		out_pair_t pair;
		if (w.req_type == REQ_COEF) begin
			coef_shadow[w.tap] = w.coef;
		end else begin
			for (int i = MAX_TAPS - 1; i > 0; i--) begin
				left_line[i]  = left_line[i-1];
				right_line[i] = right_line[i-1];
			end
			left_line[0]  = w.left;
			right_line[0] = w.right;
			// A count above the table length is clamped to the full table.
			// A count of zero sums nothing and gives zero on both channels.
			taps  = (tap_setting > MAX_TAPS) ? MAX_TAPS : int'(tap_setting);
			acc_l = 0;
			acc_r = 0;
			for (int i = 0; i < taps; i++) begin
				acc_l += longint'(left_line[i]) * longint'(coef_shadow[i]);
				acc_r += longint'(right_line[i]) * longint'(coef_shadow[i]);
			end
			// Signed division truncates toward zero. This is the Q15 scaling
			// before saturation, with no rounding.
			pair.left  = saturate(acc_l / (longint'(1) << COEF_FRAC_BITS));
			pair.right = saturate(acc_r / (longint'(1) << COEF_FRAC_BITS));
			filtered_pairs_due.push_back(pair);
		end
	endtask

	// Sample values are mostly full range. Some are small so that sums stay
	// unsaturated, and some are the extremes, zero, or plus or minus one.
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 3) begin
			case ($urandom_range(0, 4))
				0: return SAT_MAX;
				1: return SAT_MIN;
				2: return 16'sd0;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
		if (pick < 6)
			return SAMPLE_W'($urandom_range(0, 2048) - 1024);
		return SAMPLE_W'($urandom);
	endfunction

	// Coefficients are mostly scaled to the tap count in use, the way a real
	// low-pass table is. Otherwise every output would just clip. A few are
	// full range or extreme values.
	function automatic logic signed [SAMPLE_W-1:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? SAT_MAX : SAT_MIN;
			1: return SAMPLE_W'($urandom);
			default: return SAMPLE_W'($urandom_range(0, 2 * coef_span) - coef_span);
		endcase
	endfunction

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		word_t w;
		w.req_type = REQ_SAMPLE;
		w.left     = l;
		w.right    = r;
		w.tap      = 8'($urandom);
		w.coef     = SAMPLE_W'($urandom);
		pending_words.push_back(w);
	endtask

	task automatic push_coef(input int t, input logic signed [SAMPLE_W-1:0] c);
		word_t w;
		w.req_type = REQ_COEF;
		w.left     = SAMPLE_W'($urandom);
		w.right    = SAMPLE_W'($urandom);
		w.tap      = 8'(t);
		w.coef     = c;
		pending_words.push_back(w);
		coef_loaded[t] = 1'b1;
	endtask

	// Wait until every queued word has been accepted and every expected pair
	// has arrived. Then allow time for any word still in the filter to finish.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || sample_if.valid || filtered_pairs_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Start a new phase. Wait for the filter to go idle, then write the tap
	// count over APB with a setup phase and then an access phase. The new count is
	// copied into the predictor. Finally, load any table entry that the new
	// count would read and that has not been written yet.
	task automatic enter_phase(input logic [TAP_CNT_W-1:0] n);
		int lim;
		wait_idle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TAP_COUNT_ADDR;
		pwdata  <= APB_DATA_W'(n);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		tap_setting = n;
		lim         = (n > MAX_TAPS) ? MAX_TAPS : int'(n);
		coef_span   = 65536 / ((lim == 0) ? 1 : lim);
		if (coef_span > 32767)
			coef_span = 32767;
		for (int i = 0; i < lim; i++) begin
			if (!coef_loaded[i])
				push_coef(i, rand_coef());
		end
	endtask

	// Driver. Words leave the pending queue in bursts of random length, with a
	// random gap after each burst. The gaps are mostly short, but some are long
	// enough that the next word lands at any point of a computation. A word is
	// handed to the predictor at the edge where the filter accepts it.
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			burst_left      = 0;
			gap_left        = 0;
		end else begin
			if (sample_if.valid && sample_if.ready)
				filter_word(on_bus);
			if (!sample_if.valid || sample_if.ready) begin
				if (gap_left != 0 || pending_words.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					sample_if.valid <= 1'b0;
				end else begin
					on_bus = pending_words.pop_front();
					sample_if.valid        <= 1'b1;
					sample_if.req_type     <= on_bus.req_type;
					sample_if.left_sample  <= on_bus.left;
					sample_if.right_sample <= on_bus.right;
					sample_if.coef_index   <= on_bus.tap;
					sample_if.coef_value   <= on_bus.coef;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 12);
					burst_left--;
					if (burst_left == 0) begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3: gap_left = 0;
							4, 5, 6, 7, 8: gap_left = $urandom_range(1, 4);
							default: gap_left = $urandom_range(5, 300);
						endcase
					end
				end
			end
		end
	end

	// Receiver. The stall pattern switches among three modes. In one mode
	// the receiver is always ready. In another, ready changes at random every
	// cycle. In the third, ready is mostly high, with stalls that can outlast a
	// full computation so that a second finished word has to wait.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left      = 0;
			rx_mode_left    = 0;
		end else begin
			if (stall_left != 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: result_if.ready <= 1'b1;
					RX_CHOPPY: result_if.ready <= 1'($urandom_range(0, 1));
					default: begin
						result_if.ready <= 1'b1;
						if ($urandom_range(0, 99) == 0)
							stall_left = $urandom_range(1, 700);
					end
				endcase
			end
			if (rx_mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: rx_mode = RX_OPEN;
					1: rx_mode = RX_CHOPPY;
					default: rx_mode = RX_HOLDOFF;
				endcase
				rx_mode_left = $urandom_range(50, 400);
			end else begin
				rx_mode_left--;
			end
		end
	end

	// Monitor. Each output word is checked against the oldest expected pair,
	// one channel at a time.
	always @(posedge clk) begin
		out_pair_t due;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (filtered_pairs_due.size() == 0) begin
				report_mismatch($sformatf("unexpected output word left %0d right %0d",
					result_if.left_out, result_if.right_out));
			end else begin
				due = filtered_pairs_due.pop_front();
				if (result_if.left_out !== due.left)
					report_mismatch($sformatf("left_out got %0d want %0d",
						result_if.left_out, due.left));
				if (result_if.right_out !== due.right)
					report_mismatch($sformatf("right_out got %0d want %0d",
						result_if.right_out, due.right));
			end
		end
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout: filter stopped making progress");
		$display("stereo_fir_saturating_filter regression: fail");
		$finish;
	end

	initial begin
		logic [TAP_CNT_W-1:0] taps;
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		sample_if.valid        = 1'b0;
		sample_if.req_type     = REQ_SAMPLE;
		sample_if.left_sample  = '0;
		sample_if.right_sample = '0;
		sample_if.coef_index   = '0;
		sample_if.coef_value   = '0;
		result_if.ready        = 1'b0;
		rx_mode                = RX_OPEN;
		tap_setting            = TAP_COUNT_RESET;
		error_count            = 0;
		coef_span              = 256;
		for (int i = 0; i < MAX_TAPS; i++) begin
			left_line[i]   = '0;
			right_line[i]  = '0;
			coef_shadow[i] = '0;
			coef_loaded[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Single tap. Check the full-scale products, check that truncation goes
		// toward zero for small negative sums, and check that minus full scale
		// times minus full scale clips to the positive limit.
		enter_phase(TAP_CNT_W'(1));
		push_coef(0, SAT_MAX);
		push_sample(SAT_MAX, SAT_MIN);
		push_sample(-16'sd1, 16'sd1);
		push_coef(0, SAT_MIN);
		push_sample(SAT_MIN, SAT_MAX);
		push_sample(16'sd1, -16'sd1);
		push_coef(0, 16'sd1);
		push_sample(-16'sd1, SAT_MIN);

		// Two taps at full scale drive both channels into saturation: with positive
		// coefficients left clips high and right low, then with negative ones both clip high.
		enter_phase(TAP_CNT_W'(2));
		push_coef(0, SAT_MAX);
		push_coef(1, SAT_MAX);
		push_sample(SAT_MAX, SAT_MIN);
		push_sample(SAT_MAX, SAT_MIN);
		push_coef(0, SAT_MIN);
		push_coef(1, SAT_MIN);
		push_sample(SAT_MIN, SAT_MIN);
		push_sample(SAT_MIN, SAT_MIN);

		// A tap count of zero sums nothing.
		enter_phase(TAP_CNT_W'(0));
		push_sample(SAT_MAX, SAT_MIN);
		push_sample(rand_sample(), rand_sample());

		// The largest register value is clamped to the full table. This phase
		// also loads every remaining coefficient, so later phases may use any
		// tap count.
		enter_phase(TAP_CNT_W'(511));
		push_sample(SAT_MAX, SAT_MAX);
		push_sample(rand_sample(), rand_sample());
		push_sample(SAT_MIN, SAT_MIN);

		// Random phases. Each phase sets a new tap count, then sends mostly
		// sample words, with coefficient rewrites mixed in.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0: taps = TAP_CNT_W'(0);
				1: taps = TAP_CNT_W'(1);
				2: taps = TAP_CNT_W'(MAX_TAPS);
				3: taps = TAP_CNT_W'(MAX_TAPS + 1);
				4: taps = '1;
				default: taps = TAP_CNT_W'($urandom_range(2, MAX_TAPS - 1));
			endcase
			enter_phase(taps);
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if ($urandom_range(0, 9) < 7)
					push_sample(rand_sample(), rand_sample());
				else
					push_coef($urandom_range(0, MAX_TAPS - 1), rand_coef());
			end
		end

		wait_idle();
		if (error_count == 0) begin
			$display("stereo_fir_saturating_filter regression: pass");
		end else begin
			$display("stereo_fir_saturating_filter regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/fsf_pkg.sv
rtl/core/fsf_if.sv
rtl/core/fsf_cell.sv
rtl/core/fsf_mac.sv
rtl/core/stereo_fir_saturating_filter.sv
verif/testbench.sv
